[hw/rtl/sorted_list_insert_remove_assert.svh]
// assertion macros for the sorted list insert/remove checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef SORTED_LIST_INSERT_REMOVE_ASSERT_SVH
`define SORTED_LIST_INSERT_REMOVE_ASSERT_SVH

// same-cycle implication
`define SLIR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define SLIR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

[hw/rtl/slir_pkg.sv]
// shared types and constants for the sorted list insert/remove block
// no dependencies
package slir_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_INS_HEAD,
        S_HEAD_RD,
        S_HEAD_WAIT
    } t_state;

    typedef struct packed {
        t_status                    status;
        logic [COUNT_W-1:0]         element_count;
        logic                       head_valid;
        logic signed [VALUE_W-1:0]  head_value;
    } t_result;

endpackage

[hw/rtl/slir_mem.sv]
// entry store: one write port, one registered read port
// depends on slir_pkg
module slir_mem #(
    parameter int CAPACITY = slir_pkg::CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic                                i_clk,
    input  logic                                i_rd_en,
    input  logic [AW-1:0]                       i_rd_addr,
    output logic signed [slir_pkg::VALUE_W-1:0] o_rd_data,
    input  logic                                i_wr_en,
    input  logic [AW-1:0]                       i_wr_addr,
    input  logic signed [slir_pkg::VALUE_W-1:0] i_wr_data
);
    import slir_pkg::*;

    logic signed [VALUE_W-1:0] r_mem [CAPACITY];
    logic signed [VALUE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/slir_ctrl.sv]
// sequencer: walks the entry store to insert or remove one value
// depends on slir_pkg, drives slir_mem
module slir_ctrl #(
    parameter int CAPACITY = slir_pkg::CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_op,
    input  logic signed [slir_pkg::VALUE_W-1:0] i_value,
    output logic                                o_rd_en,
    output logic [AW-1:0]                       o_rd_addr,
    input  logic signed [slir_pkg::VALUE_W-1:0] i_rd_data,
    output logic                                o_wr_en,
    output logic [AW-1:0]                       o_wr_addr,
    output logic signed [slir_pkg::VALUE_W-1:0] o_wr_data,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output slir_pkg::t_result                   o_res
);
    import slir_pkg::*;

    t_state                    r_state, n_state;
    logic                      r_op, n_op;
    logic signed [VALUE_W-1:0] r_value, n_value;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic [CW-1:0]             r_left, n_left;
    logic [AW-1:0]             r_ra, n_ra;
    logic                      r_pend, n_pend;
    logic [AW-1:0]             r_pa, n_pa;
    logic                      r_found, n_found;
    t_status                   r_status, n_status;

    logic w_start;
    logic w_full;
    logic w_issue;
    logic w_eval;
    logic w_ge;
    logic w_eq;
    logic w_last;

    assign w_start = (r_state == S_IDLE) && i_in_valid;
    assign w_full  = (r_cnt == CW'(CAPACITY));
    assign w_issue = (r_state == S_SCAN) && (r_left != '0);
    assign w_eval  = (r_state == S_SCAN) && r_pend;
    assign w_ge    = (i_rd_data >= r_value);
    assign w_eq    = (i_rd_data == r_value);
    assign w_last  = (CW'(r_pa) == (r_cnt - CW'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_value  <= n_value;
        r_ra     <= n_ra;
        r_pa     <= n_pa;
        r_found  <= n_found;
        r_status <= n_status;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == OP_INSERT) begin
                        if (w_full) begin
                            n_state = S_HEAD_RD;
                        end else if (r_cnt == '0) begin
                            n_state = S_INS_HEAD;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_state = (r_cnt == '0) ? S_HEAD_RD : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_eval) begin
                    if (r_op == OP_INSERT) begin
                        if (!w_ge) begin
                            n_state = S_HEAD_RD;
                        end else if (r_pa == '0) begin
                            n_state = S_INS_HEAD;
                        end
                    end else if (w_last) begin
                        n_state = S_HEAD_RD;
                    end
                end
            end
            S_INS_HEAD: n_state = S_HEAD_RD;
            S_HEAD_RD:  n_state = S_HEAD_WAIT;
            S_HEAD_WAIT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_op       = r_op;
        n_value    = r_value;
        n_cnt      = r_cnt;
        n_left     = r_left;
        n_ra       = r_ra;
        n_pend     = 1'b0;
        n_pa       = r_pa;
        n_found    = r_found;
        n_status   = r_status;
        o_in_ready = 1'b0;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_ra;
        o_wr_en    = 1'b0;
        o_wr_addr  = '0;
        o_wr_data  = r_value;
        o_res_valid = 1'b0;
        o_res.status        = r_status;
        o_res.element_count = COUNT_W'(r_cnt);
        o_res.head_valid    = (r_cnt != '0);
        o_res.head_value    = (r_cnt != '0) ? i_rd_data : '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (w_start) begin
                    n_op     = i_op;
                    n_value  = i_value;
                    n_left   = r_cnt;
                    n_found  = 1'b0;
                    n_status = ST_DONE;
                    if (i_op == OP_INSERT) begin
                        // walk down from the top entry
                        n_ra = AW'(r_cnt - CW'(1));
                        if (w_full) begin
                            n_status = ST_FULL;
                            n_left   = '0;
                        end else begin
                            n_cnt = r_cnt + CW'(1);
                        end
                    end else begin
                        n_ra = '0;
                        if (r_cnt == '0) begin
                            n_status = ST_NOT_FOUND;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (w_issue) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_ra;
                    n_ra      = (r_op == OP_INSERT) ? (r_ra - AW'(1)) : (r_ra + AW'(1));
                    n_left    = r_left - CW'(1);
                    n_pend    = 1'b1;
                    n_pa      = r_ra;
                end
                if (w_eval) begin
                    if (r_op == OP_INSERT) begin
                        // larger or equal entries move up one place
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_pa + AW'(1);
                        o_wr_data = w_ge ? i_rd_data : r_value;
                    end else begin
                        if (r_found) begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = r_pa - AW'(1);
                            o_wr_data = i_rd_data;
                        end
                        n_found = r_found | w_eq;
                        if (w_last) begin
                            if (r_found || w_eq) begin
                                n_cnt = r_cnt - CW'(1);
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                    end
                end
                if (n_state != S_SCAN) begin
                    n_left = '0;
                    n_pend = 1'b0;
                end
            end
            S_INS_HEAD: begin
                o_wr_en   = 1'b1;
                o_wr_addr = '0;
                o_wr_data = r_value;
            end
            S_HEAD_RD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = '0;
            end
            S_HEAD_WAIT: begin
                o_res_valid = 1'b1;
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

endmodule

[hw/rtl/slir_outreg.sv]
// one-entry result register between the sequencer and the output stream
// depends on slir_pkg
module slir_outreg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  slir_pkg::t_result i_res,
    output logic              o_tvalid,
    input  logic              i_tready,
    output slir_pkg::t_result o_res
);
    import slir_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res, n_res;

    assign o_ready = !r_valid || i_tready;

    always_comb begin
        n_valid = r_valid;
        n_res   = r_res;
        if (o_ready) begin
            n_valid = i_valid;
            if (i_valid) begin
                n_res = i_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_tvalid = r_valid;
    assign o_res    = r_res;

endmodule

[hw/rtl/sorted_list_insert_remove.sv]
// channel   dir  tdata                                   tuser
// s_axis    in   [31:0] value                            [0] operation
// m_axis    out  [4:0] element_count, [5] head_valid,    [1:0] status
//                [37:6] head_value, [39:38] zero
//
// when the list is full (insert) or empty (remove) the store is not walked;
// otherwise the entry store is walked one entry per cycle through its single
// read port, shifting entries through its write port
// one item is worked on at a time; the result register frees the sequencer
// while a result waits on m_axis_tready
// reset (synchronous, active low) empties the list; the store needs no clearing
//
// top level of the sorted list insert/remove block
// depends on slir_pkg, slir_mem, slir_ctrl, slir_outreg
module sorted_list_insert_remove #(
    parameter int CAPACITY = slir_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [0:0]  s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [4:0] element_count, [5] head_valid, [37:6] head_value
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import slir_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic                      w_rd_en;
    logic [AW-1:0]             w_rd_addr;
    logic signed [VALUE_W-1:0] w_rd_data;
    logic                      w_wr_en;
    logic [AW-1:0]             w_wr_addr;
    logic signed [VALUE_W-1:0] w_wr_data;
    logic                      w_res_valid;
    logic                      w_res_ready;
    t_result                   w_res;
    t_result                   w_out;

    slir_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (s_axis_tuser[0]),
        .i_value     (s_axis_tdata),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    slir_mem #(.CAPACITY(CAPACITY)) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    slir_outreg u_outreg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_res_valid),
        .o_ready  (w_res_ready),
        .i_res    (w_res),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_res    (w_out)
    );

    assign m_axis_tdata = {2'b00, w_out.head_value, w_out.head_valid, w_out.element_count};
    assign m_axis_tuser = w_out.status;

endmodule

[hw/rtl/slir_checker.sv]
// port-level checks for the sorted list insert/remove block, bound to the top
// depends on slir_pkg and sorted_list_insert_remove_assert.svh
`include "sorted_list_insert_remove_assert.svh"

module slir_checker #(
    parameter int CAPACITY = slir_pkg::CAPACITY_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import slir_pkg::*;

    localparam bit SMALL_CAP = (CAPACITY < 32);

    logic w_in_acc;
    logic w_out_acc;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;

    // a stalled result holds
    `SLIR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    // one item at a time
    `SLIR_ASSERT_NEXT(a_one_item, w_in_acc, !s_axis_tready)
    // head flag follows the count
    `SLIR_ASSERT_NOW(a_head_flag, SMALL_CAP && m_axis_tvalid, m_axis_tdata[5] == (m_axis_tdata[4:0] != '0))
    // empty list shows a zero head
    `SLIR_ASSERT_NOW(a_empty_zero, m_axis_tvalid && !m_axis_tdata[5], m_axis_tdata[37:6] == '0)
    // a dropped insert reports a full list
    `SLIR_ASSERT_NOW(a_full_count, m_axis_tvalid && (m_axis_tuser == ST_FULL), m_axis_tdata[4:0] == COUNT_W'(CAPACITY))

    logic w_unused;
    assign w_unused = ^{s_axis_tdata, s_axis_tuser, w_out_acc};

endmodule

bind sorted_list_insert_remove slir_checker #(.CAPACITY(CAPACITY)) u_slir_checker (.*);
